[src/mstk_pkg.sv]
// ----------------------------------------------------------------------------
// mstk_pkg: shared types and constants of the max stack
// Sizes, channel payloads, cell control codes and word helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mstk_pkg;

	localparam int DEPTH      = 64;
	localparam int WIDTH      = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int PFX_LEVELS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef logic signed [WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]        count_t;

	typedef enum logic [1:0] {
		OP_PEEK    = 2'd0,
		OP_PUSH    = 2'd1,
		OP_POP     = 2'd2,
		OP_POP_MAX = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_REMOVE,
		CELL_RELAX
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RELAX,
		S_REPORT
	} state_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic signed [31:0] top_value;
		logic signed [31:0] max_value;
		logic [6:0]         entry_count;
		status_t            status;
	} rsp_t;

	// one stack entry: its value and the maximum of itself and all below
	typedef struct packed {
		word_t value;
		word_t rmax;
	} entry_t;

	// what a cell sees of its lower neighbor
	typedef struct packed {
		entry_t ent;
		logic   valid;
		logic   ok;
	} nbr_t;

	function automatic word_t to_entry(logic signed [31:0] v);
		return WIDTH'(v);
	endfunction

	function automatic logic signed [31:0] to_port(word_t w);
		return 32'(w);
	endfunction

	function automatic word_t max_w(word_t a, word_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

[src/max_stack_top.sv]
// ----------------------------------------------------------------------------
// max_stack_top: bounded stack of signed words with pop of the maximum
// A chain of cells with the top entry in cell 0; each cell caches the
// maximum of itself and every entry below it.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  cmd     | in  | cmd_valid/cmd_stall | op, push_value
//  rsp     | out | rsp_valid/rsp_stall | removed, top, max, count, status
//
//  Peek, push and pop move the cells at the accept edge; the result register
//  loads from the report state once no earlier result is stalled.
//  Pop_max removes the entry and relaxes until the top cell settles: the running
//  maximum above the removed entry is rebuilt by a wave that climbs one cell a cycle.
//  Reset clears the fill count, control state, result valid and cell settle flags;
//  entries are written before they are read. A stalled result holds in its
//  register; a new result waits in the report state, keeping the block busy,
//  until it loads; the next command is taken in the cycle after the result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module max_stack_top (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cmd_valid,
	output logic           cmd_stall,
	input  mstk_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output mstk_pkg::rsp_t rsp
);
	import mstk_pkg::*;

	state_t   state_q, state_d;
	count_t   fill_q, fill_d;
	status_t  status_q, status_d;
	logic signed [31:0] removed_q, removed_d;
	rsp_t     rsp_q, rsp_d;
	logic     rsp_valid_q;
	logic     rsp_load;
	cell_op_t cell_op;

	entry_t           cell_ent [DEPTH];
	logic [DEPTH-1:0] cell_ok;
	logic [DEPTH-1:0] match_raw;
	logic [DEPTH-1:0] match_vld;
	logic [DEPTH-1:0] shift_mask;
	entry_t           push_ent;
	logic             empty;
	logic             full;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == CNT_W'(DEPTH));

	// build the entry that a push drops into cell 0
	always_comb begin
		push_ent.value = to_entry(cmd.push_value);
		push_ent.rmax  = empty ? push_ent.value : max_w(push_ent.value, cell_ent[0].rmax);
	end

	// chain of cells, top at index 0
	for (genvar c = 0; c < DEPTH; c++) begin : g_cell
		entry_t above;
		nbr_t   below;

		if (c == 0) begin : g_first
			assign above = push_ent;
		end else begin : g_inner
			assign above = cell_ent[c-1];
		end

		if (c == DEPTH - 1) begin : g_last
			assign below = '{ent: '0, valid: 1'b0, ok: 1'b1};
		end else begin : g_mid
			assign below = '{ent: cell_ent[c+1],
				valid: (CNT_W'(c + 1) < fill_q), ok: cell_ok[c+1]};
		end

		assign match_vld[c] = match_raw[c] & (CNT_W'(c) < fill_q);

		mstk_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (cell_op),
			.from_above (above),
			.from_below (below),
			.shift_en   (shift_mask[c]),
			.stack_max  (cell_ent[0].rmax),
			.ent        (cell_ent[c]),
			.ok         (cell_ok[c]),
			.match      (match_raw[c])
		);
	end

	// cells at and below the topmost maximum close the gap
	mstk_prefix u_prefix (
		.flags  (match_vld),
		.prefix (shift_mask)
	);

	// sequence one command: apply, settle, report
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		status_d  = status_q;
		removed_d = removed_q;
		cell_op   = CELL_HOLD;
		rsp_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					status_d  = STAT_OK;
					removed_d = '0;
					state_d   = S_REPORT;
					unique case (cmd.op)
						OP_PUSH: begin
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								cell_op = CELL_PUSH;
								fill_d  = fill_q + CNT_W'(1);
							end
						end
						OP_POP: begin
							if (empty) begin
								status_d = STAT_EMPTY;
							end else begin
								cell_op   = CELL_POP;
								fill_d    = fill_q - CNT_W'(1);
								removed_d = to_port(cell_ent[0].value);
							end
						end
						OP_POP_MAX: begin
							if (empty) begin
								status_d = STAT_EMPTY;
							end else begin
								cell_op   = CELL_REMOVE;
								fill_d    = fill_q - CNT_W'(1);
								removed_d = to_port(cell_ent[0].rmax);
								state_d   = S_RELAX;
							end
						end
						OP_PEEK: begin
							cell_op = CELL_HOLD;
						end
						default: begin
							cell_op = CELL_HOLD;
						end
					endcase
				end
			end
			S_RELAX: begin
				cell_op = CELL_RELAX;
				if (cell_ok[0]) begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// assemble the result from the settled top cell
	always_comb begin
		rsp_d.removed_value = removed_q;
		rsp_d.top_value     = empty ? '0 : to_port(cell_ent[0].value);
		rsp_d.max_value     = empty ? '0 : to_port(cell_ent[0].rmax);
		rsp_d.entry_count   = 7'(fill_q);
		rsp_d.status        = status_q;
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold command results and the output register
	always_ff @(posedge clk) begin
		status_q  <= status_d;
		removed_q <= removed_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[src/mstk_cell.sv]
// ----------------------------------------------------------------------------
// mstk_cell: one slot of the stack chain
// Holds an entry and its running maximum; shifts with its neighbors on push,
// pop and removal, and rebuilds its maximum from the cell below on relax.
// ----------------------------------------------------------------------------
`default_nettype none

module mstk_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  mstk_pkg::cell_op_t  op,
	input  mstk_pkg::entry_t    from_above,
	input  mstk_pkg::nbr_t      from_below,
	input  wire                 shift_en,
	input  mstk_pkg::word_t     stack_max,
	output mstk_pkg::entry_t    ent,
	output logic                ok,
	output logic                match
);
	import mstk_pkg::*;

	entry_t ent_q;
	logic   ok_q;

	// move or rebuild the held entry
	always_ff @(posedge clk) begin
		case (op)
			CELL_PUSH:   ent_q <= from_above;
			CELL_POP:    ent_q <= from_below.ent;
			CELL_REMOVE: begin
				if (shift_en) begin
					ent_q <= from_below.ent;
				end
			end
			CELL_RELAX:  ent_q.rmax <= from_below.valid ?
				max_w(ent_q.value, from_below.ent.rmax) : ent_q.value;
			default:     ent_q <= ent_q;
		endcase
	end

	// track whether the running maximum is settled after a removal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b1;
		end else begin
			case (op)
				CELL_REMOVE: ok_q <= shift_en;
				CELL_RELAX:  ok_q <= from_below.ok;
				default:     ok_q <= ok_q;
			endcase
		end
	end

	assign ent   = ent_q;
	assign ok    = ok_q;
	assign match = (ent_q.value == stack_max);

endmodule

`default_nettype wire

[src/mstk_prefix.sv]
// ----------------------------------------------------------------------------
// mstk_prefix: prefix OR over the cell match flags
// Bit c is set when any cell from the top down to cell c matches.
// ----------------------------------------------------------------------------
`default_nettype none

module mstk_prefix (
	input  wire  [mstk_pkg::DEPTH-1:0] flags,
	output logic [mstk_pkg::DEPTH-1:0] prefix
);
	import mstk_pkg::*;

	logic [DEPTH-1:0] lvl [PFX_LEVELS+1];

	assign lvl[0] = flags;

	// fold in flags from ever farther above, doubling the span each level
	for (genvar l = 0; l < PFX_LEVELS; l++) begin : g_lvl
		assign lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
	end

	assign prefix = lvl[PFX_LEVELS];

endmodule

`default_nettype wire

[src/mstk_checker.sv]
// ----------------------------------------------------------------------------
// mstk_checker: port-level checks for the max stack
// Watches the command and result channels and flags broken behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module mstk_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            cmd_valid,
	input wire            cmd_stall,
	input wire            rsp_valid,
	input wire            rsp_stall,
	input mstk_pkg::rsp_t rsp
);
	import mstk_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// a command transfer leaves the block busy in the cycle after it
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken without a busy cycle");

	// an empty-stack report shows an empty stack and nothing removed
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_EMPTY |->
			rsp.entry_count == 7'd0 && rsp.removed_value == 32'sd0 &&
			rsp.top_value == 32'sd0 && rsp.max_value == 32'sd0)
		else $error("empty report inconsistent");

	// a full-stack report shows a full stack and nothing removed
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |->
			rsp.entry_count == 7'(DEPTH) && rsp.removed_value == 32'sd0)
		else $error("full report inconsistent");

endmodule

bind max_stack_top mstk_checker u_mstk_checker (.*);

`default_nettype wire
